[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, switched off while reset is held
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property with reset disable
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) `ASSERT_CLK(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[hw/rtl/cdd_pkg.sv]
// ---------------------------------------------------------------------------
// cdd_pkg
// shared types, constants and small tables of the civil date converter
// ---------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

    // pipeline depth: data stages plus the output register
    localparam int unsigned STG_N  = 9;
    localparam int unsigned STG_DP = STG_N - 1;

    // field widths
    localparam int unsigned W_OP    = 2;
    localparam int unsigned W_YEAR  = 14;
    localparam int unsigned W_MD    = 7;
    localparam int unsigned W_DC    = 23;
    localparam int unsigned W_LIMIT = 16;
    localparam int unsigned W_MON   = 4;
    localparam int unsigned W_DOM   = 5;

    // stream word widths
    localparam int unsigned W_TDATA_IN  = 80;
    localparam int unsigned W_TDATA_OUT = 48;

    // operation codes
    typedef enum logic [W_OP-1:0] {
        OP_TO_DAYS   = 2'd0,
        OP_FROM_DAYS = 2'd1,
        OP_AGE_CHECK = 2'd2
    } t_op;

    // register port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    typedef logic [PADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_AGE_LIMIT = '0;
    localparam logic [W_LIMIT-1:0] AGE_LIMIT_RST = 16'd90;

    // pipeline control between the stage controller and the datapaths
    typedef struct packed {
        logic [STG_N-1:0] en;
        logic [STG_N-1:0] vld;
    } t_pipe_ctl;

    // calendar constants
    localparam int unsigned ERA_YEARS   = 400;
    localparam int unsigned ERA_DAYS    = 146097;
    localparam int unsigned EPOCH_SHIFT = 719468;
    localparam int unsigned MONTH_SPAN  = 153;
    localparam int unsigned MONTH_PARTS = 5;
    localparam int unsigned YEAR_DAYS   = 365;
    localparam int unsigned QUAD_DAYS   = 1460;
    localparam int unsigned CENT_DAYS   = 36524;

    // eras added so the day count to date path stays non-negative
    localparam int unsigned ERA_BIAS     = 24;
    localparam int unsigned FROM_OFFSET  = EPOCH_SHIFT + ERA_BIAS * ERA_DAYS;
    localparam int unsigned YEAR_BIAS    = ERA_BIAS * ERA_YEARS;
    // date to day count runs with era plus one
    localparam int unsigned TO_OFFSET    = ERA_DAYS + EPOCH_SHIFT;

    localparam logic [W_DC-1:0] DC_MAX = 23'h3FFFFF;

    // reciprocal multipliers: q = (x * M) >> S, exact for the stated x width
    localparam int unsigned S_DIV400 = 24;  // x below 2^15
    localparam logic [15:0] M_DIV400 =
        16'(((longint'(1) << S_DIV400) + ERA_YEARS - 1) / ERA_YEARS);

    localparam int unsigned S_DIV5 = 18;    // x below 2^15
    localparam logic [15:0] M_DIV5 =
        16'(((longint'(1) << S_DIV5) + MONTH_PARTS - 1) / MONTH_PARTS);

    localparam int unsigned S_DIVERA = 42;  // x below 2^24
    localparam logic [24:0] M_DIVERA =
        25'(((longint'(1) << S_DIVERA) + ERA_DAYS - 1) / ERA_DAYS);

    localparam int unsigned S_DIV1460 = 29; // x below 2^18
    localparam logic [18:0] M_DIV1460 =
        19'(((longint'(1) << S_DIV1460) + QUAD_DAYS - 1) / QUAD_DAYS);

    localparam int unsigned S_DIV365 = 27;  // x below 2^18
    localparam logic [18:0] M_DIV365 =
        19'(((longint'(1) << S_DIV365) + YEAR_DAYS - 1) / YEAR_DAYS);

    localparam int unsigned S_DIV153 = 19;  // x below 2^11
    localparam int unsigned M_DIV153 =
        ((1 << S_DIV153) + MONTH_SPAN - 1) / MONTH_SPAN;
    // (5*doy + 2) * M folded into one constant product plus offset
    localparam logic [23:0] M_MP_MUL = 24'(MONTH_PARTS * M_DIV153);
    localparam logic [23:0] M_MP_ADD = 24'(2 * M_DIV153);

    // quotient by 100 of a year of era, 0..399
    function automatic logic [1:0] f_div100(input logic [8:0] v);
        logic [1:0] q;
        q = 2'(v >= 9'd100) + 2'(v >= 9'd200) + 2'(v >= 9'd300);
        return q;
    endfunction

    // first day of a march-based month within the year
    function automatic logic [8:0] f_month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cdd_pipe_ctrl.sv]
// ---------------------------------------------------------------------------
// cdd_pipe_ctrl
// valid flags and per-stage load enables; bubbles close up under a stall
// ---------------------------------------------------------------------------
`default_nettype none

module cdd_pipe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output cdd_pkg::t_pipe_ctl    o_ctl
);

    logic [cdd_pkg::STG_N-1:0] r_vld;
    logic [cdd_pkg::STG_N-1:0] n_vld;
    logic [cdd_pkg::STG_N-1:0] w_en;

    // a stage loads when empty or when its word moves on
    always_comb begin
        w_en[cdd_pkg::STG_N-1] = !r_vld[cdd_pkg::STG_N-1] || i_out_ready;
        for (int k = cdd_pkg::STG_N - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // valid flags follow the words
    always_comb begin
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < cdd_pkg::STG_N; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_vld;

endmodule

`default_nettype wire

[hw/rtl/cdd_to_days.sv]
// ---------------------------------------------------------------------------
// cdd_to_days
// year, month, day to day count, with saturation and the age compare
// ---------------------------------------------------------------------------
`default_nettype none

module cdd_to_days (
    input  logic                                i_clk,
    input  logic [cdd_pkg::STG_DP-1:0]          i_en,
    input  logic [cdd_pkg::W_YEAR-1:0]          i_year,
    input  logic [cdd_pkg::W_MD-1:0]            i_month,
    input  logic [cdd_pkg::W_MD-1:0]            i_day,
    input  logic signed [cdd_pkg::W_DC-1:0]     i_now,
    input  logic [cdd_pkg::W_LIMIT-1:0]         i_limit,
    output logic [cdd_pkg::W_DC-1:0]            o_day_count,
    output logic                                o_older,
    output logic                                o_bad
);

    // stage registers
    logic [14:0]        r0_ya, r1_ya, r2_ya;
    logic [6:0]         r0_mp;
    logic [6:0]         r0_day, r1_day, r2_day;
    logic signed [22:0] r0_now, r1_now, r2_now, r3_now, r4_now, r5_now;
    logic               r0_bad, r1_bad, r2_bad, r3_bad, r4_bad, r5_bad, r6_bad;
    logic [14:0]        r1_t;
    logic [5:0]         r2_era, r3_era, r4_era;
    logic [11:0]        r2_dsm;
    logic [8:0]         r3_yoe;
    logic signed [12:0] r3_doy;
    logic signed [18:0] r4_doe;
    logic signed [24:0] r5_dc;
    logic [22:0]        r6_dc, r7_dc;
    logic signed [25:0] r6_age;
    logic               r7_older, r7_bad;

    logic        w_early;
    logic [30:0] w_era_prod;
    logic [30:0] w_dsm_prod;
    logic [17:0] w_doe_base;
    logic [23:0] w_era_days;

    // january and february count to the previous march-based year
    assign w_early = (i_month <= 7'd2);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_ya  <= 15'(i_year) + 15'(cdd_pkg::ERA_YEARS) - 15'(w_early);
            r0_mp  <= w_early ? i_month + 7'd9 : i_month - 7'd3;
            r0_day <= i_day;
            r0_now <= i_now;
            r0_bad <= (i_month == 7'd0) || (i_month > 7'd12) ||
                      (i_day == 7'd0) || (i_day > 7'd31);
        end
    end

    // month offset numerator
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_t   <= 15'(r0_mp) * 15'(cdd_pkg::MONTH_SPAN) + 15'd2;
            r1_ya  <= r0_ya;
            r1_day <= r0_day;
            r1_now <= r0_now;
            r1_bad <= r0_bad;
        end
    end

    // era and month offset by reciprocal multiply
    assign w_era_prod = 31'(r1_ya) * 31'(cdd_pkg::M_DIV400);
    assign w_dsm_prod = 31'(r1_t) * 31'(cdd_pkg::M_DIV5);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_era <= 6'(w_era_prod >> cdd_pkg::S_DIV400);
            r2_dsm <= 12'(w_dsm_prod >> cdd_pkg::S_DIV5);
            r2_ya  <= r1_ya;
            r2_day <= r1_day;
            r2_now <= r1_now;
            r2_bad <= r1_bad;
        end
    end

    // year of era and day of year
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_yoe <= 9'(r2_ya - 15'(r2_era) * 15'(cdd_pkg::ERA_YEARS));
            r3_doy <= $signed({1'b0, r2_dsm}) + $signed(13'(r2_day)) - 13'sd1;
            r3_era <= r2_era;
            r3_now <= r2_now;
            r3_bad <= r2_bad;
        end
    end

    // day of era
    assign w_doe_base = 18'(r3_yoe) * 18'(cdd_pkg::YEAR_DAYS) + 18'(r3_yoe >> 2)
                      - 18'(cdd_pkg::f_div100(r3_yoe));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_doe <= {1'b0, w_doe_base} + {{6{r3_doy[12]}}, r3_doy};
            r4_era <= r3_era;
            r4_now <= r3_now;
            r4_bad <= r3_bad;
        end
    end

    // day count, era carried as era plus one
    assign w_era_days = 24'(r4_era) * 24'(cdd_pkg::ERA_DAYS);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_dc  <= {1'b0, w_era_days} + {{6{r4_doe[18]}}, r4_doe}
                    - 25'(cdd_pkg::TO_OFFSET);
            r5_now <= r4_now;
            r5_bad <= r4_bad;
        end
    end

    // saturate for the output and form the age
    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_dc  <= (r5_dc > $signed({2'b00, cdd_pkg::DC_MAX})) ?
                      cdd_pkg::DC_MAX : r5_dc[22:0];
            r6_age <= {{3{r5_now[22]}}, r5_now} - {r5_dc[24], r5_dc};
            r6_bad <= r5_bad;
        end
    end

    // age compare against the limit
    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_older <= !r6_bad && (r6_age > $signed({10'd0, i_limit}));
            r7_dc    <= r6_dc;
            r7_bad   <= r6_bad;
        end
    end

    assign o_day_count = r7_dc;
    assign o_older     = r7_older;
    assign o_bad       = r7_bad;

endmodule

`default_nettype wire

[hw/rtl/cdd_from_days.sv]
// ---------------------------------------------------------------------------
// cdd_from_days
// day count to year, month and day, flagging years before year zero
// ---------------------------------------------------------------------------
`default_nettype none

module cdd_from_days (
    input  logic                                i_clk,
    input  logic [cdd_pkg::STG_DP-1:0]          i_en,
    input  logic signed [cdd_pkg::W_DC-1:0]     i_day_count,
    output logic [cdd_pkg::W_YEAR-1:0]          o_year,
    output logic [cdd_pkg::W_MON-1:0]           o_month,
    output logic [cdd_pkg::W_DOM-1:0]           o_day,
    output logic                                o_neg
);

    // stage registers
    logic [23:0]        r0_zz, r1_zz;
    logic [5:0]         r1_era;
    logic [17:0]        r2_doe, r3_doe, r4_doe;
    logic [14:0]        r2_era400, r3_era400, r4_era400;
    logic [17:0]        r3_num;
    logic [8:0]         r4_yoe;
    logic [8:0]         r5_doy, r6_doy;
    logic signed [15:0] r5_yb, r6_yb;
    logic [3:0]         r6_mp;
    logic [13:0]        r7_year;
    logic [3:0]         r7_month;
    logic [4:0]         r7_day;
    logic               r7_neg;

    logic [48:0]        w_era_prod;
    logic [36:0]        w_q1460_prod;
    logic [6:0]         w_q1460;
    logic [2:0]         w_q36524;
    logic               w_qlast;
    logic [36:0]        w_yoe_prod;
    logic [17:0]        w_yoe_days;
    logic [23:0]        w_mp_prod;
    logic               w_late;
    logic signed [15:0] w_year;

    // shift the day count so every era index is non-negative
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_zz <= {i_day_count[22], i_day_count} + 24'(cdd_pkg::FROM_OFFSET);
        end
    end

    // biased era
    assign w_era_prod = 49'(r0_zz) * 49'(cdd_pkg::M_DIVERA);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_era <= 6'(w_era_prod >> cdd_pkg::S_DIVERA);
            r1_zz  <= r0_zz;
        end
    end

    // day of era and era in years
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_doe    <= 18'(r1_zz - 24'(r1_era) * 24'(cdd_pkg::ERA_DAYS));
            r2_era400 <= 15'(r1_era) * 15'(cdd_pkg::ERA_YEARS);
        end
    end

    // leap corrections of the day of era
    assign w_q1460_prod = 37'(r2_doe) * 37'(cdd_pkg::M_DIV1460);
    assign w_q1460      = 7'(w_q1460_prod >> cdd_pkg::S_DIV1460);
    assign w_q36524     = 3'(r2_doe >= 18'(cdd_pkg::CENT_DAYS))
                        + 3'(r2_doe >= 18'(2 * cdd_pkg::CENT_DAYS))
                        + 3'(r2_doe >= 18'(3 * cdd_pkg::CENT_DAYS))
                        + 3'(r2_doe >= 18'(4 * cdd_pkg::CENT_DAYS));
    assign w_qlast      = (r2_doe == 18'(cdd_pkg::ERA_DAYS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_num    <= r2_doe - 18'(w_q1460) + 18'(w_q36524) - 18'(w_qlast);
            r3_doe    <= r2_doe;
            r3_era400 <= r2_era400;
        end
    end

    // year of era
    assign w_yoe_prod = 37'(r3_num) * 37'(cdd_pkg::M_DIV365);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_yoe    <= 9'(w_yoe_prod >> cdd_pkg::S_DIV365);
            r4_doe    <= r3_doe;
            r4_era400 <= r3_era400;
        end
    end

    // day of the march-based year and the unbiased year
    assign w_yoe_days = 18'(r4_yoe) * 18'(cdd_pkg::YEAR_DAYS) + 18'(r4_yoe >> 2)
                      - 18'(cdd_pkg::f_div100(r4_yoe));

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_doy <= 9'(r4_doe - w_yoe_days);
            r5_yb  <= $signed({1'b0, r4_era400}) + $signed(16'(r4_yoe))
                    - 16'sd0 - $signed(16'(cdd_pkg::YEAR_BIAS));
        end
    end

    // march-based month index
    assign w_mp_prod = 24'(r5_doy) * cdd_pkg::M_MP_MUL + cdd_pkg::M_MP_ADD;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_mp  <= 4'(w_mp_prod >> cdd_pkg::S_DIV153);
            r6_doy <= r5_doy;
            r6_yb  <= r5_yb;
        end
    end

    // calendar month, day and year
    assign w_late = (r6_mp >= 4'd10);
    assign w_year = r6_yb + $signed(16'(w_late));

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_day   <= 5'(r6_doy - cdd_pkg::f_month_start(r6_mp) + 9'd1);
            r7_month <= w_late ? r6_mp - 4'd9 : r6_mp + 4'd3;
            r7_year  <= w_year[13:0];
            r7_neg   <= w_year[15];
        end
    end

    assign o_year  = r7_year;
    assign o_month = r7_month;
    assign o_day   = r7_day;
    assign o_neg   = r7_neg;

endmodule

`default_nettype wire

[hw/rtl/civil_date_day_number_converter_unit.sv]
// ---------------------------------------------------------------------------
// civil_date_day_number_converter_unit
// proleptic gregorian date to day count, day count to date, and age check
// ---------------------------------------------------------------------------
//  channel    direction  handshake               payload
//  s_axis     in         tvalid/tready           tuser op, tdata date fields
//  m_axis     out        tvalid/tready           tdata day count, date, flags
//  apb        in/out     psel/penable/pready     age_limit_days at byte 0
//
//  one word per cycle while the output is not stalled; each accepted word
//  passes the 8 stage datapath (the era, leap and month reciprocal
//  multiplies each own a stage) and then the output register
//  reset clears every valid flag and loads the age limit with 90
//  an output stall holds the output register; empty stages ahead of it
//  keep loading, so input is taken until the pipeline is full
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module civil_date_day_number_converter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // year_in[13:0], month_in[20:14], day_in[27:21], day_count_in[50:28],
    // now_day[73:51], zero fill[79:74]
    input  logic [cdd_pkg::W_TDATA_IN-1:0]       s_axis_tdata,
    // op[1:0]
    input  logic [cdd_pkg::W_OP-1:0]             s_axis_tuser,
    // result words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // day_count_out[22:0], year_out[36:23], month_out[40:37], day_out[45:41],
    // older[46], invalid[47]
    output logic [cdd_pkg::W_TDATA_OUT-1:0]      m_axis_tdata,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cdd_pkg::PADDR_W-1:0]          paddr,
    input  logic [cdd_pkg::PDATA_W-1:0]          pwdata,
    output logic [cdd_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    cdd_pkg::t_pipe_ctl w_ctl;

    logic [cdd_pkg::W_LIMIT-1:0] r_age_limit;
    logic [cdd_pkg::W_OP-1:0]    r_op [cdd_pkg::STG_N];

    logic [cdd_pkg::W_DC-1:0]    w_a_dc;
    logic                        w_a_older;
    logic                        w_a_bad;
    logic [cdd_pkg::W_YEAR-1:0]  w_b_year;
    logic [cdd_pkg::W_MON-1:0]   w_b_month;
    logic [cdd_pkg::W_DOM-1:0]   w_b_day;
    logic                        w_b_neg;

    logic [cdd_pkg::W_DC-1:0]    r_out_dc;
    logic [cdd_pkg::W_YEAR-1:0]  r_out_year;
    logic [cdd_pkg::W_MON-1:0]   r_out_month;
    logic [cdd_pkg::W_DOM-1:0]   r_out_day;
    logic                        r_out_older;
    logic                        r_out_invalid;

    logic                        w_reg_hit;

    // register port
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[cdd_pkg::PADDR_W-1:2] == cdd_pkg::REG_AGE_LIMIT);
    assign prdata    = w_reg_hit ?
                       cdd_pkg::PDATA_W'(r_age_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= cdd_pkg::AGE_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_age_limit <= pwdata[cdd_pkg::W_LIMIT-1:0];
        end
    end

    // stage control
    cdd_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    assign s_axis_tready = w_ctl.en[0];
    assign m_axis_tvalid = w_ctl.vld[cdd_pkg::STG_N-1];

    // op travels beside the datapaths
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_op[0] <= s_axis_tuser;
        end
        for (int k = 1; k < cdd_pkg::STG_N; k++) begin
            if (w_ctl.en[k]) begin
                r_op[k] <= r_op[k-1];
            end
        end
    end

    // date to day count and age check
    cdd_to_days u_to_days (
        .i_clk       (i_clk),
        .i_en        (w_ctl.en[cdd_pkg::STG_DP-1:0]),
        .i_year      (s_axis_tdata[13:0]),
        .i_month     (s_axis_tdata[20:14]),
        .i_day       (s_axis_tdata[27:21]),
        .i_now       (s_axis_tdata[73:51]),
        .i_limit     (r_age_limit),
        .o_day_count (w_a_dc),
        .o_older     (w_a_older),
        .o_bad       (w_a_bad)
    );

    // day count to date
    cdd_from_days u_from_days (
        .i_clk       (i_clk),
        .i_en        (w_ctl.en[cdd_pkg::STG_DP-1:0]),
        .i_day_count (s_axis_tdata[50:28]),
        .o_year      (w_b_year),
        .o_month     (w_b_month),
        .o_day       (w_b_day),
        .o_neg       (w_b_neg)
    );

    // output register: pick the fields of the requested operation
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[cdd_pkg::STG_N-1]) begin
            r_out_dc      <= '0;
            r_out_year    <= '0;
            r_out_month   <= '0;
            r_out_day     <= '0;
            r_out_older   <= 1'b0;
            r_out_invalid <= 1'b0;
            unique case (r_op[cdd_pkg::STG_DP-1])
                cdd_pkg::OP_TO_DAYS: begin
                    r_out_dc <= w_a_dc;
                end
                cdd_pkg::OP_FROM_DAYS: begin
                    if (w_b_neg) begin
                        r_out_invalid <= 1'b1;
                    end else begin
                        r_out_year  <= w_b_year;
                        r_out_month <= w_b_month;
                        r_out_day   <= w_b_day;
                    end
                end
                cdd_pkg::OP_AGE_CHECK: begin
                    r_out_older   <= w_a_older;
                    r_out_invalid <= w_a_bad;
                end
                default: begin
                    r_out_invalid <= 1'b0;
                end
            endcase
        end
    end

    assign m_axis_tdata = {r_out_invalid, r_out_older, r_out_day, r_out_month,
                           r_out_year, r_out_dc};

    // checks
    `ASSERT_NXT(a_accept_loads, s_axis_tvalid && s_axis_tready, w_ctl.vld[0], "accepted word missing in first stage")
    `ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")
    `ASSERT_IMP(a_flags_exclusive, m_axis_tvalid, !(r_out_older && r_out_invalid), "older and invalid both set")
    `ASSERT_IMP(a_to_days_no_flags, m_axis_tvalid && (r_op[cdd_pkg::STG_N-1] == cdd_pkg::OP_TO_DAYS), !r_out_older && !r_out_invalid, "flag set on a date to day count word")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stream and register bench for the civil date converter: outside the steady phase,
// words go in with random gaps and results leave under random back-pressure, and
// every output word is checked field by field against an in-bench calendar predictor
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // op code that the block leaves unused
    localparam logic [cdd_pkg::W_OP-1:0] OP_UNUSED = 2'd3;
    // cycles without any handshake before the run is declared hung
    localparam int unsigned STALL_LIMIT = 1000;
    // extra cycles after the last result so stray words can show up
    localparam int unsigned TAIL_CYCLES = 2 * cdd_pkg::STG_N + 4;
    localparam longint DAY_COUNT_SAT = 64'sd4194303;
    localparam longint SERIAL_MIN = -64'sd719528;
    localparam longint SERIAL_SPAN = 64'sd3652424;

    // one result word, split into its fields
    typedef struct {
        logic [cdd_pkg::W_DC-1:0]   day_count;
        logic [cdd_pkg::W_YEAR-1:0] year;
        logic [cdd_pkg::W_MON-1:0]  month;
        logic [cdd_pkg::W_DOM-1:0]  dom;
        logic                       older;
        logic                       invalid;
    } t_conv_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cdd_pkg::W_TDATA_IN-1:0]  s_axis_tdata = '0;
    logic [cdd_pkg::W_OP-1:0]        s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cdd_pkg::W_TDATA_OUT-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [cdd_pkg::PADDR_W-1:0]     paddr = '0;
    logic [cdd_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [cdd_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    // bench-side copy of the age limit register
    logic [cdd_pkg::W_LIMIT-1:0] age_limit = cdd_pkg::AGE_LIMIT_RST;
    t_conv_word                  expected_words[$];
    int                          error_count = 0;
    bit                          steady = 1'b0;
    bit                          watch_on = 1'b0;
    int unsigned                 quiet_cycles = 0;

    civil_date_day_number_converter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // days since the epoch for a civil date
    function automatic longint days_from_date(input longint y, input longint m,
                                              input longint d);
        longint yy, era, yoe, doy, doe;
        yy = (m <= 2) ? y - 1 : y;
        era = ((yy >= 0) ? yy : yy - 399) / 400;
        yoe = yy - era * 400;
        doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // civil date for a day count
    function automatic void date_from_days(input longint z, output longint y,
                                           output longint m, output longint d);
        longint zz, era, doe, yoe, doy, mp;
        zz = z + 719468;
        era = ((zz >= 0) ? zz : zz - 146096) / 146097;
        doe = zz - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = (mp < 10) ? mp + 3 : mp - 9;
        y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    // expected result word for one input word
    function automatic t_conv_word predict_word(input logic [cdd_pkg::W_OP-1:0] op,
                                                input logic [cdd_pkg::W_YEAR-1:0] yr,
                                                input logic [cdd_pkg::W_MD-1:0] mon,
                                                input logic [cdd_pkg::W_MD-1:0] dom,
                                                input logic [cdd_pkg::W_DC-1:0] count,
                                                input logic [cdd_pkg::W_DC-1:0] today);
        t_conv_word w;
        longint dc, cy, cm, cd, age;
        w = '{default: '0};
        case (op)
            cdd_pkg::OP_TO_DAYS: begin
                // month and day go through unchecked, large years saturate
                dc = days_from_date(longint'(yr), longint'(mon), longint'(dom));
                if (dc > DAY_COUNT_SAT) dc = DAY_COUNT_SAT;
                w.day_count = dc[cdd_pkg::W_DC-1:0];
            end
            cdd_pkg::OP_FROM_DAYS: begin
                date_from_days(longint'($signed(count)), cy, cm, cd);
                if (cy < 0) begin
                    w.invalid = 1'b1;
                end else begin
                    w.year  = cy[cdd_pkg::W_YEAR-1:0];
                    w.month = cm[cdd_pkg::W_MON-1:0];
                    w.dom   = cd[cdd_pkg::W_DOM-1:0];
                end
            end
            cdd_pkg::OP_AGE_CHECK: begin
                if (mon < 1 || mon > 12 || dom < 1 || dom > 31) begin
                    w.invalid = 1'b1;
                end else begin
                    age = longint'($signed(today))
                        - days_from_date(longint'(yr), longint'(mon), longint'(dom));
                    w.older = (age > longint'(age_limit));
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    // one input word, with random idle cycles ahead of it
    task automatic send_item(input logic [cdd_pkg::W_OP-1:0] op,
                             input logic [cdd_pkg::W_YEAR-1:0] yr,
                             input logic [cdd_pkg::W_MD-1:0] mon,
                             input logic [cdd_pkg::W_MD-1:0] dom,
                             input logic [cdd_pkg::W_DC-1:0] count,
                             input logic [cdd_pkg::W_DC-1:0] today);
        while (!steady && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(cdd_pkg::W_TDATA_IN - 74){1'b0}}, today, count, dom, mon, yr};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_words.insert(expected_words.size(),
                              predict_word(op, yr, mon, dom, count, today));
    endtask

    // stop sending and wait until every expected word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_age_limit(input logic [cdd_pkg::PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cdd_pkg::PADDR_W'({cdd_pkg::REG_AGE_LIMIT, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        age_limit = value[cdd_pkg::W_LIMIT-1:0];
    endtask

    // date to day count: epoch, leap day, extremes, unchecked month and day
    task automatic test_to_days();
        send_item(cdd_pkg::OP_TO_DAYS, 14'd1970, 7'd1, 7'd1, 23'($urandom), 23'($urandom));
        send_item(cdd_pkg::OP_TO_DAYS, 14'd2000, 7'd2, 7'd29, '0, '0);
        send_item(cdd_pkg::OP_TO_DAYS, 14'd0, 7'd0, 7'd0, '1, '1);
        send_item(cdd_pkg::OP_TO_DAYS, 14'd9999, 7'd12, 7'd31, '0, '1);
        send_item(cdd_pkg::OP_TO_DAYS, '1, '1, '1, '1, '0);
        send_item(cdd_pkg::OP_TO_DAYS, 14'd2024, 7'd13, 7'd0, '0, '0);
    endtask

    // day count to date: epoch, range ends, negative years, field extremes
    task automatic test_from_days();
        send_item(cdd_pkg::OP_FROM_DAYS, '0, '0, '0, 23'd0, '0);
        send_item(cdd_pkg::OP_FROM_DAYS, '1, '1, '1, 23'(SERIAL_MIN), '1);
        send_item(cdd_pkg::OP_FROM_DAYS, '0, '0, '0, 23'(SERIAL_MIN - 1), '0);
        send_item(cdd_pkg::OP_FROM_DAYS, '0, '0, '0, 23'(SERIAL_MIN + SERIAL_SPAN), '0);
        send_item(cdd_pkg::OP_FROM_DAYS, '1, '1, '1, 23'h400000, '1);
        send_item(cdd_pkg::OP_FROM_DAYS, '0, '0, '0, 23'h3FFFFF, '0);
    endtask

    // age check around the limit, bad dates, and both limit extremes
    task automatic test_age_check();
        longint base;
        base = days_from_date(2000, 1, 1);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base + 90));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base + 91));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base - 5));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd0, 7'd1, '0, '1);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd13, 7'd31, '0, '1);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd6, 7'd0, '0, '1);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd6, 7'd32, '0, '1);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd1999, 7'd2, 7'd31, '0, 23'h3FFFFF);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd9999, 7'd12, 7'd31, '0, 23'h400000);
        drain_results();
        write_age_limit(32'd0);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base + 1));
        drain_results();
        write_age_limit(32'hFFFF_FFFF);
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base + 65535));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd2000, 7'd1, 7'd1, '0, 23'(base + 65536));
        send_item(cdd_pkg::OP_AGE_CHECK, 14'd0, 7'd1, 7'd1, '1, 23'h3FFFFF);
    endtask

    // unused op code returns an all-zero word
    task automatic test_unused_op();
        send_item(OP_UNUSED, '1, '1, '1, '1, '1);
        send_item(OP_UNUSED, 14'($urandom), 7'($urandom), 7'($urandom),
                  23'($urandom), 23'($urandom));
    endtask

    // one random word, mostly well formed with random content
    task automatic random_item();
        logic [cdd_pkg::W_OP-1:0]   op;
        logic [cdd_pkg::W_YEAR-1:0] yr;
        logic [cdd_pkg::W_MD-1:0]   mon;
        logic [cdd_pkg::W_MD-1:0]   dom;
        logic [cdd_pkg::W_DC-1:0]   count;
        logic [cdd_pkg::W_DC-1:0]   today;
        int unsigned                pick;
        longint                     base;
        op    = cdd_pkg::W_OP'($urandom);
        yr    = cdd_pkg::W_YEAR'($urandom);
        mon   = cdd_pkg::W_MD'($urandom);
        dom   = cdd_pkg::W_MD'($urandom);
        count = cdd_pkg::W_DC'($urandom);
        today = cdd_pkg::W_DC'($urandom);
        pick  = $urandom_range(99);
        if (pick < 30) begin
            op = cdd_pkg::OP_TO_DAYS;
            if ($urandom_range(9) < 8) begin
                yr  = cdd_pkg::W_YEAR'($urandom_range(0, 9999));
                mon = cdd_pkg::W_MD'($urandom_range(1, 12));
                dom = cdd_pkg::W_MD'($urandom_range(1, 31));
            end
        end else if (pick < 60) begin
            op = cdd_pkg::OP_FROM_DAYS;
            if ($urandom_range(9) < 7) begin
                count = cdd_pkg::W_DC'(SERIAL_MIN
                                       + longint'($urandom_range(0, SERIAL_SPAN)));
            end else if ($urandom_range(1) == 0) begin
                count = cdd_pkg::W_DC'(SERIAL_MIN + longint'($urandom_range(0, 4)) - 2);
            end
        end else if (pick < 90) begin
            op = cdd_pkg::OP_AGE_CHECK;
            if ($urandom_range(9) < 8) begin
                yr   = cdd_pkg::W_YEAR'($urandom_range(0, 9999));
                mon  = cdd_pkg::W_MD'($urandom_range(1, 12));
                dom  = cdd_pkg::W_MD'($urandom_range(1, 31));
                base = days_from_date(longint'(yr), longint'(mon), longint'(dom));
                // land on both sides of the limit most of the time
                if ($urandom_range(9) < 6) begin
                    today = cdd_pkg::W_DC'(base + longint'(age_limit)
                                           + longint'($urandom_range(0, 4)) - 2);
                end else if ($urandom_range(1) == 0) begin
                    today = cdd_pkg::W_DC'(base + longint'($urandom_range(0, 400)) - 200);
                end
            end
        end else if (pick < 94) begin
            op = OP_UNUSED;
        end
        send_item(op, yr, mon, dom, count, today);
    endtask

    // random words under several limit settings, with a mid-phase pause
    task automatic test_random_mixed();
        logic [cdd_pkg::PDATA_W-1:0] limits[5];
        limits[0] = $urandom;
        limits[1] = 32'd0;
        limits[2] = {16'($urandom), 16'hFFFF};
        limits[3] = 32'(cdd_pkg::AGE_LIMIT_RST);
        limits[4] = 32'($urandom_range(0, 400));
        foreach (limits[p]) begin
            drain_results();
            write_age_limit(limits[p]);
            for (int n = 0; n < 150; n++) begin
                steady = (p == 0 && n < 100);
                if (p == 2 && n == 75) drain_results();
                random_item();
            end
        end
        steady = 1'b0;
    endtask

    // output side: random back-pressure and field-by-field check
    always @(posedge i_clk) begin
        t_conv_word want;
        t_conv_word got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.day_count = m_axis_tdata[22:0];
            got.year      = m_axis_tdata[36:23];
            got.month     = m_axis_tdata[40:37];
            got.dom       = m_axis_tdata[45:41];
            got.older     = m_axis_tdata[46];
            got.invalid   = m_axis_tdata[47];
            if (expected_words.size() == 0) begin
                $error("unexpected result word 'h%0h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (got.day_count !== want.day_count) begin
                    $error("day_count_out: expected %0d actual %0d",
                           $signed(want.day_count), $signed(got.day_count));
                    error_count++;
                end
                if (got.year !== want.year) begin
                    $error("year_out: expected %0d actual %0d", want.year, got.year);
                    error_count++;
                end
                if (got.month !== want.month) begin
                    $error("month_out: expected %0d actual %0d", want.month, got.month);
                    error_count++;
                end
                if (got.dom !== want.dom) begin
                    $error("day_out: expected %0d actual %0d", want.dom, got.dom);
                    error_count++;
                end
                if (got.older !== want.older) begin
                    $error("older: expected %0d actual %0d", want.older, got.older);
                    error_count++;
                end
                if (got.invalid !== want.invalid) begin
                    $error("invalid: expected %0d actual %0d", want.invalid, got.invalid);
                    error_count++;
                end
            end
        end
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (watch_on) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable && pready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        watch_on = 1'b1;
        @(posedge i_clk);
        test_to_days();
        test_from_days();
        test_unused_op();
        test_age_check();
        test_random_mixed();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
